FILE: src/sece_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sece_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [7:0] YBase    = 8'd240;
  localparam logic [9:0] XOffset  = 10'd15;
  localparam logic [8:0] YOffset  = 9'd16;
  localparam logic [5:0] TopColour = 6'h38;

  typedef struct packed {
    logic [15:0] base_tile;
    logic [8:0]  sx;
    logic [7:0]  sy;
    logic [5:0]  colour;
    logic        fx;
    logic        fy;
    logic [1:0]  pri;
    logic        top;
    logic        big;
  } entry_t;

  typedef struct packed {
    logic        push;
  } q_wr_t;

  typedef struct packed {
    logic        valid;
  } q_rd_t;

endpackage
`default_nettype wire

FILE: src/sece_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sece_entry_if;
  logic        valid;
  logic        ready;
  logic [15:0] attr_word;
  logic [15:0] pos_word;
  logic [15:0] tile_word;

  modport source (output valid, attr_word, pos_word, tile_word, input ready);
  modport sink   (input valid, attr_word, pos_word, tile_word, output ready);
endinterface

interface sece_cell_if;
  logic               valid;
  logic               ready;
  logic        [16:0] cell_tile;
  logic signed [9:0]  cell_x;
  logic signed [8:0]  cell_y;
  logic        [5:0]  cell_colour;
  logic               mirror_x;
  logic               mirror_y;
  logic        [1:0]  draw_priority;
  logic               top_palette;
  logic               last_cell;

  modport source (output valid, cell_tile, cell_x, cell_y, cell_colour, mirror_x,
                  mirror_y, draw_priority, top_palette, last_cell, input ready);
  modport sink   (input valid, cell_tile, cell_x, cell_y, cell_colour, mirror_x,
                  mirror_y, draw_priority, top_palette, last_cell, output ready);
endinterface
`default_nettype wire

FILE: src/sece_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sece_front import sece_pkg::*; (
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] attr_word_i,
  input  logic [15:0] pos_word_i,
  input  logic [15:0] tile_word_i,
  input  logic        full_i,
  output q_wr_t       wr_o,
  output entry_t      entry_o
);

  logic [5:0] colour;

  assign colour  = pos_word_i[14:9];
  assign ready_o = !full_i;

  always_comb begin
    wr_o.push = valid_i && !full_i;
  end

  always_comb begin
    entry_o.big       = !attr_word_i[11];
    entry_o.base_tile = attr_word_i[11] ? tile_word_i : {tile_word_i[15:2], 2'b00};
    entry_o.sx        = pos_word_i[8:0];
    entry_o.sy        = YBase - attr_word_i[7:0];
    entry_o.colour    = colour;
    entry_o.fx        = attr_word_i[14];
    entry_o.fy        = attr_word_i[15];
    entry_o.pri       = attr_word_i[13:12];
    entry_o.top       = (colour >= TopColour);
  end

endmodule
`default_nettype wire

FILE: src/sece_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sece_queue import sece_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_wr_t  wr_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output q_rd_t  rd_o,
  output entry_t data_o
);

  entry_t         slot_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0] cnt_q, cnt_d;
  logic           do_pop;

  assign full_o = (cnt_q == QCw'(QDepth));
  assign do_pop = pop_i && (cnt_q != '0);
  assign data_o = slot_q[rd_ptr_q];

  always_comb begin
    rd_o.valid = (cnt_q != '0);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i.push) begin
      wr_ptr_d = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({wr_i.push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/sece_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sece_back import sece_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_rd_t              rd_i,
  input  entry_t             entry_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic        [16:0] cell_tile_o,
  output logic signed [9:0]  cell_x_o,
  output logic signed [8:0]  cell_y_o,
  output logic        [5:0]  cell_colour_o,
  output logic               mirror_x_o,
  output logic               mirror_y_o,
  output logic        [1:0]  draw_priority_o,
  output logic               top_palette_o,
  output logic               last_cell_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       advance;
  logic       row, col, ec, er, last;

  logic        [16:0] tile_q, tile_d;
  logic        [9:0]  x_q, x_d;
  logic        [8:0]  y_q, y_d;
  logic        [5:0]  colour_q;
  logic               fx_q, fy_q, top_q, last_q;
  logic        [1:0]  pri_q;

  assign advance = !valid_q || ready_i;
  assign row     = entry_i.big & idx_q[1];
  assign col     = entry_i.big & idx_q[0];
  assign ec      = col ^ (entry_i.big & entry_i.fx);
  assign er      = row ^ (entry_i.big & entry_i.fy);
  assign last    = !entry_i.big || (idx_q == 2'b11);
  assign pop_o   = advance && rd_i.valid && last;

  always_comb begin
    tile_d  = {1'b0, entry_i.base_tile} + {15'd0, ec, er};
    x_d     = {1'b0, entry_i.sx} + {6'd0, col, 3'b000} - XOffset;
    y_d     = {1'b0, entry_i.sy} + {5'd0, row, 3'b000} - YOffset;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (advance) begin
      valid_d = rd_i.valid;
      if (rd_i.valid) begin
        idx_d = last ? 2'b00 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'b00;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rd_i.valid) begin
      tile_q   <= tile_d;
      x_q      <= x_d;
      y_q      <= y_d;
      colour_q <= entry_i.colour;
      fx_q     <= entry_i.fx;
      fy_q     <= entry_i.fy;
      pri_q    <= entry_i.pri;
      top_q    <= entry_i.top;
      last_q   <= last;
    end
  end

  assign valid_o         = valid_q;
  assign cell_tile_o     = tile_q;
  assign cell_x_o        = signed'(x_q);
  assign cell_y_o        = signed'(y_q);
  assign cell_colour_o   = colour_q;
  assign mirror_x_o      = fx_q;
  assign mirror_y_o      = fy_q;
  assign draw_priority_o = pri_q;
  assign top_palette_o   = top_q;
  assign last_cell_o     = last_q;

endmodule
`default_nettype wire

FILE: src/sprite_entry_cell_expander.sv
// Expands one sprite entry (attribute, position and tile words) into its 8x8 cells, row
// by row and left to right, one cell per output beat. A single-cell entry gives one cell,
// a 2x2 entry four; the output channel at one cell per beat sets the pace. Entries are
// classified on entry and held in a two-deep queue, so new entries keep being accepted
// while the cell generator works or the output stalls, until the queue is full. The first
// cell of a newly accepted entry is registered in the queue, then in the output stage.
`timescale 1ns / 1ps
`default_nettype none
module sprite_entry_cell_expander import sece_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sece_entry_if.sink    entry_i,
  sece_cell_if.source   cell_o
);

  q_wr_t  wr;
  q_rd_t  rd;
  entry_t front_entry;
  entry_t queue_entry;
  logic   full;
  logic   pop;

  sece_front u_front (
    .valid_i     (entry_i.valid),
    .ready_o     (entry_i.ready),
    .attr_word_i (entry_i.attr_word),
    .pos_word_i  (entry_i.pos_word),
    .tile_word_i (entry_i.tile_word),
    .full_i      (full),
    .wr_o        (wr),
    .entry_o     (front_entry)
  );

  sece_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .data_i (front_entry),
    .full_o (full),
    .pop_i  (pop),
    .rd_o   (rd),
    .data_o (queue_entry)
  );

  sece_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rd_i            (rd),
    .entry_i         (queue_entry),
    .pop_o           (pop),
    .valid_o         (cell_o.valid),
    .ready_i         (cell_o.ready),
    .cell_tile_o     (cell_o.cell_tile),
    .cell_x_o        (cell_o.cell_x),
    .cell_y_o        (cell_o.cell_y),
    .cell_colour_o   (cell_o.cell_colour),
    .mirror_x_o      (cell_o.mirror_x),
    .mirror_y_o      (cell_o.mirror_y),
    .draw_priority_o (cell_o.draw_priority),
    .top_palette_o   (cell_o.top_palette),
    .last_cell_o     (cell_o.last_cell)
  );

endmodule
`default_nettype wire

FILE: src/sece_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sece_checker import sece_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        ready_i,
  input  logic [16:0] cell_tile_i,
  input  logic [5:0]  cell_colour_i,
  input  logic        mirror_x_i,
  input  logic        mirror_y_i,
  input  logic [1:0]  draw_priority_i,
  input  logic        top_palette_i,
  input  logic        last_cell_i
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(cell_tile_i) && $stable(last_cell_i))
    else $error("stalled cell beat changed");

  // tile numbers never carry past 16 bits
  a_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !cell_tile_i[16])
    else $error("cell tile overflow");

  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (top_palette_i == (cell_colour_i >= TopColour)))
    else $error("top palette flag mismatch");

  // cells of one entry follow without a gap and share their attributes
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !last_cell_i |=> valid_i && $stable(cell_colour_i) &&
      $stable(mirror_x_i) && $stable(mirror_y_i) && $stable(draw_priority_i))
    else $error("cell burst broken");

endmodule

bind sprite_entry_cell_expander sece_checker u_sece_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (cell_o.valid),
  .ready_i         (cell_o.ready),
  .cell_tile_i     (cell_o.cell_tile),
  .cell_colour_i   (cell_o.cell_colour),
  .mirror_x_i      (cell_o.mirror_x),
  .mirror_y_i      (cell_o.mirror_y),
  .draw_priority_i (cell_o.draw_priority),
  .top_palette_i   (cell_o.top_palette),
  .last_cell_i     (cell_o.last_cell)
);
`default_nettype wire
